@@ rtl/pwtd_pkg.sv @@
// Shared types, widths and defaults for the PID controller with timestamped derivative.
`timescale 1ns / 1ps
`default_nettype none

package pwtd_pkg;

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int TIME_W    = 48;
    localparam int ERR_W     = 33;
    localparam int DE_W      = 34;
    localparam int DERIV_W   = 48;
    localparam int GAIN_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Shared multiplier: 64-bit operands taken in two 32-bit chunks
    localparam int MUL_OP_W  = 64;
    localparam int CHUNK_W   = 32;
    localparam int PROD_W    = 65;
    localparam int ACC_W     = 98;
    localparam int MUL_STEPS = 6;
    localparam int MSEL_W    = 3;

    // Parameter defaults
    localparam int DEF_TICKS_PER_SECOND = 1000000;
    localparam int DEF_FRAC_BITS        = 16;
    localparam int DEF_INTEGRAL_WIDTH   = 48;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP  = 2'd0,
        CFG_INTEG = 2'd1,
        CFG_DERIV = 2'd2
    } t_cfg_idx;

    // Product terms of the output sum
    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_I = 2'd1,
        TERM_D = 2'd2
    } t_term;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_INT,
        S_ABS,
        S_SCALE,
        S_DIV,
        S_DSAT,
        S_MUL,
        S_MACC,
        S_ROUND,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load_in;
        logic              calc_err;
        logic              calc_int;
        logic              calc_abs;
        logic              calc_scale;
        logic              div_step;
        logic              calc_dsat;
        logic              mul_issue;
        logic              mul_acc;
        logic [MSEL_W-1:0] mul_sel;
        logic              round;
        logic              finish;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic use_deriv;
        logic out_free;
    } t_status;

    // Width of the scaled change in error, which is also the quotient width
    function automatic int f_div_w(input int tps);
        return DE_W + $clog2(tps + 1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/pwtd_ctrl.sv @@
// Sequencing state machine for the PID controller.
`timescale 1ns / 1ps
`default_nettype none

module pwtd_ctrl
    import pwtd_pkg::*;
#(
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam int DIV_W = f_div_w(TICKS_PER_SECOND);
    localparam int CNT_W = $clog2(DIV_W);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_div_last;
    logic             w_mul_last;
    logic             w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_div_last = (r_cnt == CNT_W'(DIV_W - 1));
    assign w_mul_last = (r_cnt == CNT_W'(MUL_STEPS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_ERR;
            S_ERR:   n_state = S_INT;
            S_INT:   n_state = i_status.use_deriv ? S_ABS : S_MUL;
            S_ABS:   n_state = S_SCALE;
            S_SCALE: n_state = S_DIV;
            S_DIV:   if (w_div_last) n_state = S_DSAT;
            S_DSAT:  n_state = S_MUL;
            S_MUL:   if (w_mul_last) n_state = S_MACC;
            S_MACC:  n_state = S_ROUND;
            S_ROUND: n_state = S_DONE;
            S_DONE:  if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Step counter for the divider and the multiplier, cleared on every state change
    always_comb begin
        if (n_state != r_state) begin
            n_cnt = '0;
        end else begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    // Commands to the datapath
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.load_in    = w_accept;
            S_ERR:   o_cmd.calc_err   = 1'b1;
            S_INT:   o_cmd.calc_int   = 1'b1;
            S_ABS:   o_cmd.calc_abs   = 1'b1;
            S_SCALE: o_cmd.calc_scale = 1'b1;
            S_DIV:   o_cmd.div_step   = 1'b1;
            S_DSAT:  o_cmd.calc_dsat  = 1'b1;
            S_MUL: begin
                o_cmd.mul_issue = 1'b1;
                o_cmd.mul_sel   = r_cnt[MSEL_W-1:0];
                o_cmd.mul_acc   = (r_cnt != '0);
            end
            S_MACC:  o_cmd.mul_acc    = 1'b1;
            S_ROUND: o_cmd.round      = 1'b1;
            S_DONE:  o_cmd.finish     = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // An accepted beat always starts the error step
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_ERR))
        else $error("accepted beat did not start the error step");

    // A result is only written when the output register can take it
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_status.out_free)
        else $error("result written over an unread beat");

    // The divider never runs past its quotient width
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (int'(r_cnt) < DIV_W))
        else $error("division step count overran");

endmodule

`default_nettype wire

@@ rtl/pwtd_dp.sv @@
// Datapath: gains, controller state, divider, shared multiplier and output register.
`timescale 1ns / 1ps
`default_nettype none

module pwtd_dp
    import pwtd_pkg::*;
#(
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND,
    parameter int FRAC_BITS        = DEF_FRAC_BITS,
    parameter int INTEGRAL_WIDTH   = DEF_INTEGRAL_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [GAIN_W-1:0]    i_cfg_data,
    input  wire logic [DATA_W-1:0]    i_target,
    input  wire logic [DATA_W-1:0]    i_measured,
    input  wire logic [TIME_W-1:0]    i_time_ticks,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    output logic [DATA_W-1:0]         o_drive,
    output logic                      o_output_saturated,
    output logic                      o_zero_interval,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall
);

    localparam int DIV_W = f_div_w(TICKS_PER_SECOND);
    localparam int TPS_W = DIV_W - DE_W;
    localparam int IW    = INTEGRAL_WIDTH;
    localparam logic [TPS_W-1:0] TPS_C = TPS_W'(TICKS_PER_SECOND);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [MUL_OP_W-1:0] DERIV_NEG_LIM = MUL_OP_W'(1) << (DERIV_W - 1);

    // Gain registers
    logic signed [GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d;

    // Input beat and per-item working registers
    logic signed [DATA_W-1:0]  r_target, r_measured;
    logic [TIME_W-1:0]         r_time;
    logic signed [ERR_W-1:0]   r_err;
    logic [TIME_W-1:0]         r_dt;
    logic signed [DE_W-1:0]    r_de;
    logic                      r_de_neg;
    logic [DE_W-1:0]           r_de_mag;
    logic [DIV_W-1:0]          r_num;
    logic [TIME_W-1:0]         r_rem;
    logic signed [DERIV_W-1:0] r_deriv;
    logic                      r_use_deriv, r_zero_iv;
    logic                      r_sat;

    // Controller state carried between items
    logic signed [IW-1:0]      r_int;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic [TIME_W-1:0]         r_prev_time;
    logic                      r_have_prev;

    // Multiplier and accumulator
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prod_hi;
    logic signed [ACC_W-1:0]   r_acc;

    // Output register
    logic [DATA_W-1:0]         r_drive;
    logic                      r_out_sat, r_out_zero, r_out_valid;

    logic signed [IW:0]        w_int_sum;
    logic                      w_int_ovf;
    logic signed [IW-1:0]      w_int_clip;
    logic                      w_dt_zero;
    logic [DIV_W-1:0]          w_scaled;
    logic [TIME_W:0]           w_rem_sh;
    logic [TIME_W+1:0]         w_rem_diff;
    logic                      w_rem_ge;
    logic [MUL_OP_W-1:0]       w_q64;
    logic                      w_q_big;
    logic [MUL_OP_W-1:0]       w_op;
    logic signed [CHUNK_W:0]   w_chunk;
    logic signed [GAIN_W-1:0]  w_gain;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_addend;
    logic [ACC_W-FRAC_BITS-DATA_W:0] w_top;
    logic                      w_fits;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROP:  r_gain_p <= i_cfg_data;
                CFG_INTEG: r_gain_i <= i_cfg_data;
                CFG_DERIV: r_gain_d <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Saturating integral update
    assign w_int_sum  = (IW + 1)'(r_int) + (IW + 1)'(r_err);
    assign w_int_ovf  = (w_int_sum[IW] != w_int_sum[IW-1]);
    assign w_int_clip = w_int_ovf ? (w_int_sum[IW] ? {1'b1, {(IW - 1){1'b0}}}
                                                   : {1'b0, {(IW - 1){1'b1}}})
                                  : w_int_sum[IW-1:0];
    assign w_dt_zero  = (r_dt == '0);

    // Change in error scaled to ticks per second
    assign w_scaled = DIV_W'(r_de_mag) * DIV_W'(TPS_C);

    // One restoring division step
    assign w_rem_sh   = {r_rem, r_num[DIV_W-1]};
    assign w_rem_diff = {1'b0, w_rem_sh} - {2'b00, r_dt};
    assign w_rem_ge   = !w_rem_diff[TIME_W+1];

    // Quotient saturation to the derivative range
    assign w_q64   = MUL_OP_W'(r_num);
    assign w_q_big = r_de_neg ? (w_q64 > DERIV_NEG_LIM) : (|w_q64[MUL_OP_W-1:DERIV_W-1]);

    // Operand and chunk selection for the shared multiplier
    always_comb begin
        case (t_term'(i_cmd.mul_sel[MSEL_W-1:1]))
            TERM_P: begin
                w_op   = MUL_OP_W'(r_err);
                w_gain = r_gain_p;
            end
            TERM_I: begin
                w_op   = MUL_OP_W'(r_int);
                w_gain = r_gain_i;
            end
            TERM_D: begin
                w_op   = MUL_OP_W'(r_deriv);
                w_gain = r_gain_d;
            end
            default: begin
                w_op   = '0;
                w_gain = '0;
            end
        endcase
    end

    assign w_chunk  = i_cmd.mul_sel[0] ? (CHUNK_W + 1)'(signed'(w_op[MUL_OP_W-1:CHUNK_W]))
                                       : {1'b0, w_op[CHUNK_W-1:0]};
    assign w_prod   = PROD_W'(w_chunk) * PROD_W'(w_gain);
    assign w_addend = r_prod_hi ? (ACC_W'(r_prod) <<< CHUNK_W) : ACC_W'(r_prod);

    // Rounded sum fits the drive range when all bits above it match its sign
    assign w_top  = r_acc[ACC_W-1:FRAC_BITS+DATA_W-1];
    assign w_fits = (&w_top) || !(|w_top);

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_target   <= i_target;
            r_measured <= i_measured;
            r_time     <= i_time_ticks;
        end
        if (i_cmd.calc_err) begin
            r_err <= ERR_W'(r_measured) - ERR_W'(r_target);
            r_dt  <= r_time - r_prev_time;
            r_acc <= '0;
            r_sat <= 1'b0;
        end
        if (i_cmd.calc_int) begin
            r_de     <= DE_W'(r_err) - DE_W'(r_prev_err);
            r_deriv  <= '0;
            if (w_int_ovf) begin
                r_sat <= 1'b1;
            end
        end
        if (i_cmd.calc_abs) begin
            r_de_neg <= r_de[DE_W-1];
            r_de_mag <= r_de[DE_W-1] ? DE_W'(-r_de) : DE_W'(r_de);
        end
        if (i_cmd.calc_scale) begin
            r_num <= w_scaled;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_rem_ge ? w_rem_diff[TIME_W-1:0] : w_rem_sh[TIME_W-1:0];
            r_num <= {r_num[DIV_W-2:0], w_rem_ge};
        end
        if (i_cmd.calc_dsat) begin
            if (w_q_big) begin
                r_sat   <= 1'b1;
                r_deriv <= r_de_neg ? {1'b1, {(DERIV_W - 1){1'b0}}}
                                    : {1'b0, {(DERIV_W - 1){1'b1}}};
            end else begin
                r_deriv <= r_de_neg ? -signed'(w_q64[DERIV_W-1:0])
                                    : signed'(w_q64[DERIV_W-1:0]);
            end
        end
        if (i_cmd.mul_issue) begin
            r_prod    <= w_prod;
            r_prod_hi <= i_cmd.mul_sel[0];
        end
        if (i_cmd.mul_acc) begin
            r_acc <= r_acc + w_addend;
        end
        if (i_cmd.round) begin
            r_acc <= r_acc + HALF;
        end
        if (i_cmd.finish) begin
            r_out_zero <= r_zero_iv;
            if (w_fits) begin
                r_drive   <= r_acc[FRAC_BITS+DATA_W-1:FRAC_BITS];
                r_out_sat <= r_sat;
            end else begin
                r_drive   <= r_acc[ACC_W-1] ? {1'b1, {(DATA_W - 1){1'b0}}}
                                            : {1'b0, {(DATA_W - 1){1'b1}}};
                r_out_sat <= 1'b1;
            end
        end
    end

    // Previous sample, integral and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int       <= '0;
            r_prev_err  <= '0;
            r_prev_time <= '0;
            r_have_prev <= 1'b0;
            r_use_deriv <= 1'b0;
            r_zero_iv   <= 1'b0;
        end else begin
            if (i_cmd.calc_int) begin
                r_int       <= w_int_clip;
                r_prev_err  <= r_err;
                r_prev_time <= r_time;
                r_have_prev <= 1'b1;
                r_use_deriv <= r_have_prev && !w_dt_zero;
                r_zero_iv   <= r_have_prev && w_dt_zero;
            end
        end
    end

    // Output valid: set by a new result, cleared when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.use_deriv = r_have_prev && !w_dt_zero;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_drive            = r_drive;
    assign o_output_saturated = r_out_sat;
    assign o_zero_interval    = r_out_zero;
    assign o_out_valid        = r_out_valid;

    // A zero interval and a computed derivative exclude each other
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_zero_iv && r_use_deriv))
        else $error("zero interval and derivative both flagged");

    // The partial remainder stays below the elapsed ticks while dividing
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_dt))
        else $error("division remainder out of range");

    // Once a sample has been seen, a previous sample always exists
    a_prev_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_have_prev) |-> r_have_prev)
        else $error("previous sample lost");

endmodule

`default_nettype wire

@@ rtl/pid_with_timestamped_derivative.sv @@
// Top level of the positional PID controller with timestamped derivative.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_stall    i_target, i_measured, i_time_ticks
//   out       output     o_out_valid / i_out_stall  o_drive, o_output_saturated,
//                                                   o_zero_interval
//   cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// An item with a derivative steps through the error, integral, magnitude, scale,
// divide, saturate, multiply, accumulate, round and done states, where the divider
// yields one quotient bit per cycle over DIV_W = 34 + clog2(TICKS_PER_SECOND + 1) bits.
// The first item and items with a zero interval skip magnitude through saturate.
// Reset is synchronous and clears gains, integral, previous sample and valid flags.
// A result held by i_out_stall sits in the output register while the next beat
// is accepted; that next result waits until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module pid_with_timestamped_derivative
    import pwtd_pkg::*;
#(
    parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND,
    parameter int FRAC_BITS        = DEF_FRAC_BITS,
    parameter int INTEGRAL_WIDTH   = DEF_INTEGRAL_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [GAIN_W-1:0]    i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [DATA_W-1:0]    i_target,
    input  wire logic [DATA_W-1:0]    i_measured,
    input  wire logic [TIME_W-1:0]    i_time_ticks,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [DATA_W-1:0]         o_drive,
    output logic                      o_output_saturated,
    output logic                      o_zero_interval
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer
    pwtd_ctrl #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and storage
    pwtd_dp #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND),
        .FRAC_BITS       (FRAC_BITS),
        .INTEGRAL_WIDTH  (INTEGRAL_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_target           (i_target),
        .i_measured         (i_measured),
        .i_time_ticks       (i_time_ticks),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_drive            (o_drive),
        .o_output_saturated (o_output_saturated),
        .o_zero_interval    (o_zero_interval),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall)
    );

endmodule

`default_nettype wire
